/* rtl/saa_pkg.sv */
// Shared constants, payload types and page-entry layout for the shelf atlas allocator.
package saa_pkg;

   localparam int PAGE_SIZE  = 1024;
   localparam int MAX_PAGES  = 8;
   localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int COUNT_W    = $clog2(MAX_PAGES + 1);

   localparam logic [1:0] ST_PLACED   = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [10:0] rect_width;
      logic [10:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  page_index;
      logic        opened_page;
      logic [10:0] left_x;
      logic [10:0] top_y;
      logic [10:0] right_x;
      logic [10:0] bottom_y;
   } rsp_type;

   typedef struct packed {
      logic [10:0] cursor_column;
      logic [11:0] shelf_top;
      logic [10:0] shelf_tallest;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* rtl/saa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module saa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/shelf_atlas_allocator_core.sv */
// Shelf atlas allocator: size check, page scan over the page RAM, page opening, response.
//
// Usage: a request transaction (req_valid/req_stall, req_data) carries a rectangle
// size; exactly one response transaction (rsp_valid/rsp_stall, rsp_data) follows,
// in order. The padding register is written through csr_valid/csr_ready/csr_wdata,
// which is always ready; write it only while no request is in flight.
// A request is size-checked first; a rejected size goes straight to the response,
// else open pages are tried in order, and if none fits a new page is opened, or
// the status is full once MAX_PAGES pages are open. Page state sits in one RAM
// with one read port and is visited one page per cycle; one request is processed
// at a time, and req_stall stays high until its response enters the output register.
// Reset: padding returns to 1 and no page is open; the RAM is not cleared, as a
// page entry is always written when the page opens, before it is read.
// The finished response sits in an output register; a new request may be
// accepted while it waits. If the receiver stalls, the next response is held
// internally and req_stall stays high until the output register frees up.
module shelf_atlas_allocator_core
   import saa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_OPEN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [3:0]            pad_ff, pad_in;
   logic [10:0]           w_ff, w_in, h_ff, h_in;
   logic [PAGE_IDX_W-1:0] page_ff, page_in;
   logic [COUNT_W-1:0]    open_cnt_ff, open_cnt_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [PAGE_IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;
   entry_type             base, upd;

   logic [11:0]           adv_x, adv_y, w_span, h_span;
   logic [12:0]           col_end, top_sum, row_end;
   logic [11:0]           top1;
   logic [10:0]           cur1, tall1;
   logic                  new_shelf, fits, reject;
   logic [COUNT_W-1:0]    next_page;

   saa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (upd),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // placement on one page; a fresh page starts at (padding, padding, 0)
   always_comb begin
      if (state_ff == S_OPEN) begin
         base.cursor_column = 11'(pad_ff);
         base.shelf_top     = 12'(pad_ff);
         base.shelf_tallest = '0;
      end else begin
         base = entry_type'(ram_rd_data);
      end
      adv_x     = 12'(w_ff) + 12'(pad_ff);
      adv_y     = 12'(h_ff) + 12'(pad_ff);
      col_end   = 13'(base.cursor_column) + 13'(adv_x);
      new_shelf = col_end > 13'(PAGE_SIZE);
      top_sum   = 13'(base.shelf_top) + 13'(base.shelf_tallest) + 13'(pad_ff);
      if (new_shelf) begin
         // saturate: any top past the page edge fails for good
         top1  = top_sum[12] ? 12'hfff : top_sum[11:0];
         cur1  = 11'(pad_ff);
         tall1 = '0;
      end else begin
         top1  = base.shelf_top;
         cur1  = base.cursor_column;
         tall1 = base.shelf_tallest;
      end
      row_end = 13'(top1) + 13'(adv_y);
      fits    = row_end <= 13'(PAGE_SIZE);
      upd.shelf_top = top1;
      if (fits) begin
         upd.cursor_column = 11'(12'(cur1) + adv_x);
         upd.shelf_tallest = (h_ff > tall1) ? h_ff : tall1;
      end else begin
         upd.cursor_column = cur1;
         upd.shelf_tallest = tall1;
      end
   end

   always_comb begin
      w_span = 12'(w_ff) + 12'({pad_ff, 1'b0});
      h_span = 12'(h_ff) + 12'({pad_ff, 1'b0});
      reject = (w_ff == '0) || (h_ff == '0) ||
               (w_span > 12'(PAGE_SIZE)) || (h_span > 12'(PAGE_SIZE));
      next_page = COUNT_W'(page_ff) + COUNT_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      page_in      = page_ff;
      open_cnt_in  = open_cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = page_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      if (csr_valid) begin
         pad_in = csr_wdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               w_in     = req_data.rect_width;
               h_in     = req_data.rect_height;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in = '0;
            if (reject) begin
               res_in.status = ST_REJECTED;
               state_in      = S_DONE;
            end else if (open_cnt_ff == '0) begin
               state_in = S_OPEN;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               page_in     = '0;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            // write back this page (shelf move is kept on failure), prefetch the next
            ram_wr_en   = 1'b1;
            ram_wr_addr = page_ff;
            if (fits) begin
               res_in.status     = ST_PLACED;
               res_in.page_index = 3'(page_ff);
               res_in.left_x     = cur1;
               res_in.top_y      = 11'(top1);
               res_in.right_x    = 11'(12'(cur1) + 12'(w_ff));
               res_in.bottom_y   = 11'(top1 + 12'(h_ff));
               state_in          = S_DONE;
            end else if (next_page < open_cnt_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = PAGE_IDX_W'(next_page);
               page_in     = PAGE_IDX_W'(next_page);
            end else if (open_cnt_ff == COUNT_W'(MAX_PAGES)) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_OPEN;
            end
         end
         S_OPEN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = PAGE_IDX_W'(open_cnt_ff);
            open_cnt_in = open_cnt_ff + COUNT_W'(1);
            if (fits) begin
               res_in.status      = ST_PLACED;
               res_in.page_index  = 3'(open_cnt_ff);
               res_in.opened_page = 1'b1;
               res_in.left_x      = cur1;
               res_in.top_y       = 11'(top1);
               res_in.right_x     = 11'(12'(cur1) + 12'(w_ff));
               res_in.bottom_y    = 11'(top1 + 12'(h_ff));
            end else begin
               res_in.status = ST_FULL;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pad_ff       <= 4'd1;
         open_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         open_cnt_ff  <= open_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff        <= w_in;
      h_ff        <= h_in;
      page_ff     <= page_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= COUNT_W'(MAX_PAGES))
      else $error("open page count beyond limit");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("page RAM read and write hit the same entry");

   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN) |=> (open_cnt_ff == $past(open_cnt_ff) + COUNT_W'(1)))
      else $error("page open did not advance the page count");

   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_PLACED)) |->
      (rsp_data.left_x == '0 && rsp_data.top_y == '0 && rsp_data.page_index == '0
       && rsp_data.opened_page == 1'b0))
      else $error("failed transaction carries placement fields");

   a_eval_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (COUNT_W'(page_ff) < open_cnt_ff))
      else $error("scan visiting a page that is not open");

endmodule
